/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off during
// the active-low reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property failed");

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

/* sv/dpq_pkg.sv */
// ----------------------------------------------------------------------------
// dpq_pkg
// Types, constants and table functions of the dithered palette quantizer.
// ----------------------------------------------------------------------------
package dpq_pkg;

  typedef logic [7:0]         chan_t;
  typedef logic signed [8:0]  delta_t;
  typedef logic [15:0]        sq_t;
  typedef logic [17:0]        dist_t;

  // One ANSI candidate during the minimum search.
  typedef struct packed {
    dist_t      dsum;
    logic [3:0] idx;
  } cand_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_DITHER = 2'd1;
  localparam logic [1:0] REG_AMP    = 2'd2;

  // Palette modes.
  localparam logic MODE_XTERM = 1'b0;
  localparam logic MODE_ANSI  = 1'b1;

  localparam int NumChan   = 3;
  localparam int NumAnsi   = 16;
  localparam int NumLevels = 4;
  localparam int NumGray   = 24;
  localparam int GrayBase  = 8;
  localparam int GrayStep  = 10;
  localparam int GrayIdx0  = 232;
  localparam int CubeIdx0  = 16;
  localparam int BayerMid  = 8;

  // 4x4 Bayer matrix entry.
  function automatic logic [3:0] bayer_val(logic [1:0] row, logic [1:0] col);
    logic [3:0] v;
    case ({row, col})
      4'h0: v = 4'd0;   4'h1: v = 4'd8;   4'h2: v = 4'd2;   4'h3: v = 4'd10;
      4'h4: v = 4'd12;  4'h5: v = 4'd4;   4'h6: v = 4'd14;  4'h7: v = 4'd6;
      4'h8: v = 4'd3;   4'h9: v = 4'd11;  4'ha: v = 4'd1;   4'hb: v = 4'd9;
      4'hc: v = 4'd15;  4'hd: v = 4'd7;   4'he: v = 4'd13;  4'hf: v = 4'd5;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

  // Channel value of a color cube level.
  function automatic chan_t cube_level(logic [2:0] i);
    chan_t v;
    case (i)
      3'd0: v = 8'd0;
      3'd1: v = 8'd95;
      3'd2: v = 8'd135;
      3'd3: v = 8'd175;
      3'd4: v = 8'd215;
      3'd5: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Nearest cube level; a value exactly between two levels takes the lower.
  function automatic logic [2:0] nearest_cube(chan_t v);
    logic [2:0] i;
    if (v <= 8'd47)       i = 3'd0;
    else if (v <= 8'd115) i = 3'd1;
    else if (v <= 8'd155) i = 3'd2;
    else if (v <= 8'd195) i = 3'd3;
    else if (v <= 8'd235) i = 3'd4;
    else                  i = 3'd5;
    return i;
  endfunction

  // Channel value of an ANSI component level code.
  function automatic chan_t ansi_level(logic [1:0] code);
    chan_t v;
    case (code)
      2'd0: v = 8'd0;
      2'd1: v = 8'd128;
      2'd2: v = 8'd192;
      2'd3: v = 8'd255;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // Level codes {red, green, blue} of the 16 ANSI colors.
  function automatic logic [5:0] ansi_code(logic [3:0] i);
    logic [5:0] c;
    case (i)
      4'd0:  c = {2'd0, 2'd0, 2'd0};
      4'd1:  c = {2'd1, 2'd0, 2'd0};
      4'd2:  c = {2'd0, 2'd1, 2'd0};
      4'd3:  c = {2'd1, 2'd1, 2'd0};
      4'd4:  c = {2'd0, 2'd0, 2'd1};
      4'd5:  c = {2'd1, 2'd0, 2'd1};
      4'd6:  c = {2'd0, 2'd1, 2'd1};
      4'd7:  c = {2'd2, 2'd2, 2'd2};
      4'd8:  c = {2'd1, 2'd1, 2'd1};
      4'd9:  c = {2'd3, 2'd0, 2'd0};
      4'd10: c = {2'd0, 2'd3, 2'd0};
      4'd11: c = {2'd3, 2'd3, 2'd0};
      4'd12: c = {2'd0, 2'd0, 2'd3};
      4'd13: c = {2'd3, 2'd0, 2'd3};
      4'd14: c = {2'd0, 2'd3, 2'd3};
      4'd15: c = {2'd3, 2'd3, 2'd3};
      default: c = 6'd0;
    endcase
    return c;
  endfunction

  // Squared difference of two channel values.
  function automatic sq_t sq_diff(chan_t a, chan_t b);
    chan_t d;
    d = (a >= b) ? (a - b) : (b - a);
    return sq_t'(d) * sq_t'(d);
  endfunction

  // Keep the lower-index candidate a unless b is strictly nearer.
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.dsum < a.dsum) ? b : a;
  endfunction

endpackage

/* sv/dithered_palette_quantizer_core.sv */
// ----------------------------------------------------------------------------
// dithered_palette_quantizer_core
// Maps one RGB pixel to an xterm-256 or ANSI-16 palette index, with optional
// 4x4 Bayer ordered dither, in a seven-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  ----------------------------
//  pixel     in         start / busy              red, green, blue, row/col phase
//  result    out        result_valid_o (strobe)   palette_index_o
//  config    in/out     APB psel/penable/pready   palette_mode, dither_enable,
//                                                 dither_amplitude
//
// One item enters per cycle; its result strobes on result_valid_o after it
// has passed the registered stages in order: dither offset, clamp, level
// and gray selection, squares, distance sums, and a two-stage registered
// minimum tree. busy stays low, as the pipeline never stalls and the
// receiver takes every result. Reset clears the configuration registers and
// the valid bits of all stages.

`include "assert_macros.svh"

module dithered_palette_quantizer_core
  import dpq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Pixel input
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  input  logic [1:0]  row_phase_i,
  input  logic [1:0]  col_phase_i,
  // Result output
  output logic        result_valid_o,
  output logic [7:0]  palette_index_o,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration registers.
  logic        mode_q;
  logic        dither_q;
  logic [7:0]  amp_q;
  logic        cfg_wr;

  // Valid bit of each stage.
  logic [7:1]  vld_q;

  // Stage payloads.
  logic        s1_mode_q;
  chan_t       s1_ch_q [NumChan];
  delta_t      s1_delta_q;

  logic        s2_mode_q;
  chan_t       s2_ch_q [NumChan];

  logic        s3_mode_q;
  chan_t       s3_ch_q [NumChan];
  logic [2:0]  s3_lvl_q [NumChan];
  logic [4:0]  s3_gidx_q;

  logic        s4_mode_q;
  logic [2:0]  s4_lvl_q [NumChan];
  logic [4:0]  s4_gidx_q;
  sq_t         s4_cube_sq_q [NumChan];
  sq_t         s4_gray_sq_q [NumChan];
  sq_t         s4_ansi_sq_q [NumChan][NumLevels];

  logic        s5_mode_q;
  logic [4:0]  s5_gidx_q;
  logic [7:0]  s5_cube_idx_q;
  dist_t       s5_cube_d_q;
  dist_t       s5_gray_d_q;
  dist_t       s5_ansi_d_q [NumAnsi];

  logic        s6_mode_q;
  logic [7:0]  s6_xterm_q;
  cand_t       s6_cand_q [4];

  logic        s7_mode_q;
  logic [7:0]  palette_index_q;

  // Combinational stage results.
  logic signed [4:0]  boff;
  logic signed [13:0] prod;
  logic signed [13:0] prod_adj;
  delta_t             delta_d;
  chan_t              clamp_d [NumChan];
  logic [9:0]         chan_sum;
  logic [22:0]        gray_gt;
  logic [4:0]         gidx_d;
  chan_t              gray_lvl;
  dist_t              ansi_d_d [NumAnsi];
  cand_t              ansi_c [NumAnsi];
  cand_t              cand_d [4];
  cand_t              ansi_win;
  logic [7:0]         xterm_d;
  logic [7:0]         index_d;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register writes; an address past the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_XTERM;
      dither_q <= 1'b0;
      amp_q    <= 8'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE:   mode_q   <= pwdata[0];
        REG_DITHER: dither_q <= pwdata[0];
        REG_AMP:    amp_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[3:2])
      REG_MODE:   prdata = {31'd0, mode_q};
      REG_DITHER: prdata = {31'd0, dither_q};
      REG_AMP:    prdata = {24'd0, amp_q};
      default:    prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake and valid pipeline
  // --------------------------------------------------------------------------

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[6:1], start && !busy};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: dither offset, (bayer - 8) * amplitude / 8 toward zero
  // --------------------------------------------------------------------------

  always_comb begin
    boff     = $signed({1'b0, bayer_val(row_phase_i, col_phase_i)}) - 5'(BayerMid);
    prod     = boff * $signed({1'b0, amp_q});
    prod_adj = prod + ((prod < 0) ? 14'sd7 : 14'sd0);
    delta_d  = dither_q ? delta_t'(prod_adj >>> 3) : '0;
  end

  always_ff @(posedge clk_i) begin
    s1_mode_q  <= mode_q;
    s1_ch_q[0] <= red_i;
    s1_ch_q[1] <= green_i;
    s1_ch_q[2] <= blue_i;
    s1_delta_q <= delta_d;
  end

  // --------------------------------------------------------------------------
  // Stage 2: add offset and clamp each channel to 0..255
  // --------------------------------------------------------------------------

  always_comb begin
    logic signed [9:0] sum;
    for (int c = 0; c < NumChan; c++) begin
      sum = $signed({2'b00, s1_ch_q[c]}) + s1_delta_q;
      if (sum < 0)            clamp_d[c] = 8'd0;
      else if (sum > 10'sd255) clamp_d[c] = 8'd255;
      else                    clamp_d[c] = sum[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    s2_mode_q <= s1_mode_q;
    s2_ch_q   <= clamp_d;
  end

  // --------------------------------------------------------------------------
  // Stage 3: nearest cube level per channel and nearest gray.
  // The gray distance is convex in the gray level, so gray i+1 beats gray i
  // exactly when 3*gray_i + 15 < r + g + b; counting those steps gives the
  // nearest gray, the earlier one on a tie.
  // --------------------------------------------------------------------------

  always_comb begin
    chan_sum = 10'(s2_ch_q[0]) + 10'(s2_ch_q[1]) + 10'(s2_ch_q[2]);
    for (int i = 0; i < NumGray - 1; i++) begin
      gray_gt[i] = chan_sum > 10'(3 * (GrayBase + GrayStep * i) + 15);
    end
    gidx_d = 5'($countones(gray_gt));
  end

  always_ff @(posedge clk_i) begin
    s3_mode_q <= s2_mode_q;
    s3_ch_q   <= s2_ch_q;
    s3_gidx_q <= gidx_d;
    for (int c = 0; c < NumChan; c++) begin
      s3_lvl_q[c] <= nearest_cube(s2_ch_q[c]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: squared channel differences
  // --------------------------------------------------------------------------

  assign gray_lvl = 8'(GrayBase) + 8'(s3_gidx_q) * 8'(GrayStep);

  always_ff @(posedge clk_i) begin
    s4_mode_q <= s3_mode_q;
    s4_lvl_q  <= s3_lvl_q;
    s4_gidx_q <= s3_gidx_q;
    for (int c = 0; c < NumChan; c++) begin
      s4_cube_sq_q[c] <= sq_diff(s3_ch_q[c], cube_level(s3_lvl_q[c]));
      s4_gray_sq_q[c] <= sq_diff(s3_ch_q[c], gray_lvl);
      for (int k = 0; k < NumLevels; k++) begin
        s4_ansi_sq_q[c][k] <= sq_diff(s3_ch_q[c], ansi_level(2'(k)));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: distance sums and cube index
  // --------------------------------------------------------------------------

  always_comb begin
    logic [5:0] code;
    for (int i = 0; i < NumAnsi; i++) begin
      code        = ansi_code(4'(i));
      ansi_d_d[i] = 18'(s4_ansi_sq_q[0][code[5:4]])
                  + 18'(s4_ansi_sq_q[1][code[3:2]])
                  + 18'(s4_ansi_sq_q[2][code[1:0]]);
    end
  end

  always_ff @(posedge clk_i) begin
    s5_mode_q     <= s4_mode_q;
    s5_gidx_q     <= s4_gidx_q;
    s5_cube_idx_q <= 8'(CubeIdx0) + 8'(s4_lvl_q[0]) * 8'd36
                   + 8'(s4_lvl_q[1]) * 8'd6 + 8'(s4_lvl_q[2]);
    s5_cube_d_q   <= 18'(s4_cube_sq_q[0]) + 18'(s4_cube_sq_q[1])
                   + 18'(s4_cube_sq_q[2]);
    s5_gray_d_q   <= 18'(s4_gray_sq_q[0]) + 18'(s4_gray_sq_q[1])
                   + 18'(s4_gray_sq_q[2]);
    s5_ansi_d_q   <= ansi_d_d;
  end

  // --------------------------------------------------------------------------
  // Stage 6: gray replaces the cube color only when strictly nearer;
  // first two levels of the ANSI minimum tree.
  // --------------------------------------------------------------------------

  always_comb begin
    for (int i = 0; i < NumAnsi; i++) begin
      ansi_c[i].dsum = s5_ansi_d_q[i];
      ansi_c[i].idx  = 4'(i);
    end
    for (int g = 0; g < 4; g++) begin
      cand_d[g] = pick(pick(ansi_c[4*g],     ansi_c[4*g + 1]),
                       pick(ansi_c[4*g + 2], ansi_c[4*g + 3]));
    end
    xterm_d = (s5_gray_d_q < s5_cube_d_q) ? 8'(GrayIdx0) + 8'(s5_gidx_q)
                                          : s5_cube_idx_q;
  end

  always_ff @(posedge clk_i) begin
    s6_mode_q  <= s5_mode_q;
    s6_xterm_q <= xterm_d;
    s6_cand_q  <= cand_d;
  end

  // --------------------------------------------------------------------------
  // Stage 7: last ANSI levels and mode select into the output register
  // --------------------------------------------------------------------------

  always_comb begin
    ansi_win = pick(pick(s6_cand_q[0], s6_cand_q[1]),
                    pick(s6_cand_q[2], s6_cand_q[3]));
    index_d  = (s6_mode_q == MODE_ANSI) ? {4'd0, ansi_win.idx} : s6_xterm_q;
  end

  always_ff @(posedge clk_i) begin
    s7_mode_q       <= s6_mode_q;
    palette_index_q <= index_d;
  end

  assign result_valid_o  = vld_q[7];
  assign palette_index_o = palette_index_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An ANSI result always lies in 0..15.
  `ASSERT_CLK(a_ansi_range, (vld_q[7] && s7_mode_q == MODE_ANSI) |-> (palette_index_q[7:4] == 4'd0))
  // An xterm result never falls into the 16 system colors.
  `ASSERT_NEVER(a_xterm_range, vld_q[7] && s7_mode_q == MODE_XTERM && palette_index_q < 8'(CubeIdx0))
  // A gray index is chosen only when the gray was strictly nearer.
  `ASSERT_CLK(a_gray_pick, (vld_q[6] && s6_xterm_q >= 8'(GrayIdx0)) |-> ($past(s5_gray_d_q) < $past(s5_cube_d_q)))

endmodule
